// File: sv/uud_pkg.sv
// shared types and codes for the uudecode line stream core
// no dependencies; used by every module of the block except the line store
`default_nettype none

package uud_pkg;

	// result kind carried on the output tuser
	typedef enum logic [2:0] {
		ST_DATA    = 3'd0,
		ST_END     = 3'd1,
		ST_BADHDR  = 3'd2,
		ST_BADLINE = 3'd3,
		ST_NOEND   = 3'd4
	} status_t;

	// one queue entry: what a single text character asks the back end to emit
	typedef struct packed {
		logic       has_line;
		logic       bank;
		logic [5:0] count;
		logic       has_stat;
		status_t    stat;
	} cmd_t;

	// back end hands a drained line bank back to the front end
	typedef struct packed {
		logic valid;
		logic bank;
	} rel_t;

endpackage

`default_nettype wire

// File: sv/uud_lstore.sv
// two-bank line store: one write port, one registered read port
// no package dependencies
`default_nettype none

module uud_lstore #(
	parameter int DEPTH = 63,
	parameter int AW    = 6
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic          wr_bank,
	input  wire logic [AW-1:0] wr_idx,
	input  wire logic [7:0]    wr_data,
	input  wire logic          rd_en,
	input  wire logic          rd_bank,
	input  wire logic [AW-1:0] rd_idx,
	output logic      [7:0]    rd_data
);

	logic [7:0] mem [2][DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_bank][wr_idx] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_bank][rd_idx];
		end
	end

endmodule

`default_nettype wire

// File: sv/uud_cmdq.sv
// two-entry command queue between the front and back ends
// depends on uud_pkg (cmd_t)
`default_nettype none

module uud_cmdq (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire uud_pkg::cmd_t push_cmd,
	output logic               full,
	input  wire logic          pop,
	output uud_pkg::cmd_t      head,
	output logic               empty
);

	uud_pkg::cmd_t ent_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    fill_q;

	assign full  = (fill_q == 2'd2);
	assign empty = (fill_q == 2'd0);
	assign head  = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: sv/uud_front.sv
// front end: takes text characters, tracks line state, decodes sextets into
// the line store and queues one command per character that has results; uses uud_pkg
`default_nettype none

module uud_front #(
	parameter int MAX_LINE_BYTES = 63,
	parameter int AW             = 6
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic [7:0]    in_char,
	input  wire logic          in_fin,
	output logic               cmd_push,
	output uud_pkg::cmd_t      cmd,
	input  wire logic          q_full,
	input  wire uud_pkg::rel_t rel,
	output logic               wr_en,
	output logic               wr_bank,
	output logic [AW-1:0]      wr_idx,
	output logic [7:0]         wr_data
);

	typedef enum logic [1:0] {PH_HDR, PH_DATA, PH_DONE} phase_t;

	localparam logic [7:0] LF          = 8'h0A;
	localparam logic [7:0] SPACE       = 8'h20;
	localparam logic [5:0] MAX_CNT     = 6'(MAX_LINE_BYTES);
	localparam logic [7:0] HDR_TEXT [6] = '{8'h62, 8'h65, 8'h67, 8'h69, 8'h6E, 8'h20};
	localparam logic [7:0] END_TEXT [3] = '{8'h65, 8'h6E, 8'h64};

	phase_t     phase_q, ph_n;
	logic [6:0] pos_q, pos_n;
	logic [5:0] cnt_q, cnt_n;
	logic [5:0] carry_q, carry_n;
	logic [5:0] dec_q, dec_n;
	logic [2:0] pm_q, pm_n;
	logic       wbank_q;
	logic [1:0] busy_q;
	logic [1:0] busy_clr;
	logic [1:0] busy_set;

	logic       accept;
	logic       emit;
	logic [5:0] emit_cnt;
	logic       stat_v;
	uud_pkg::status_t stat;
	logic [5:0] sx;
	logic [1:0] grp;
	logic       end_hit;

	assign in_ready = !q_full && !busy_q[wbank_q];
	assign accept   = in_valid && in_ready;
	assign cmd_push = accept && (emit || stat_v);
	assign wr_bank  = wbank_q;
	assign wr_idx   = dec_q[AW-1:0];

	// bank released by the back end, bank claimed by a line handed over
	assign busy_clr = {rel.valid && rel.bank, rel.valid && !rel.bank};
	assign busy_set = {accept && emit && wbank_q, accept && emit && !wbank_q};

	assign cmd.has_line = emit;
	assign cmd.bank     = wbank_q;
	assign cmd.count    = emit_cnt;
	assign cmd.has_stat = stat_v;
	assign cmd.stat     = stat;

	always_comb begin
		ph_n     = phase_q;
		pos_n    = pos_q;
		cnt_n    = cnt_q;
		carry_n  = carry_q;
		dec_n    = dec_q;
		pm_n     = pm_q;
		wr_en    = 1'b0;
		wr_data  = 8'd0;
		emit     = 1'b0;
		emit_cnt = cnt_q;
		stat_v   = 1'b0;
		stat     = uud_pkg::ST_DATA;
		sx       = in_char[5:0] - 6'h20;
		grp      = pos_q[1:0] - 2'd1;
		end_hit  = 1'b0;
		unique case (phase_q)
			PH_HDR: begin
				if (pm_q < 3'd6) begin
					if (in_char == HDR_TEXT[pm_q]) begin
						pm_n = pm_q + 3'd1;
					end else begin
						stat_v = 1'b1;
						stat   = uud_pkg::ST_BADHDR;
						ph_n   = PH_DONE;
					end
				end else if (in_char == LF) begin
					pos_n   = 7'd0;
					cnt_n   = 6'd0;
					carry_n = 6'd0;
					dec_n   = 6'd0;
					pm_n    = 3'd0;
					ph_n    = PH_DATA;
				end
			end
			PH_DATA: begin
				// "end" prefix tracking over the first three characters
				if (pos_q < 7'd3 && {4'd0, pm_q} == pos_q &&
						in_char == END_TEXT[pos_q[1:0]]) begin
					pm_n    = pm_q + 3'd1;
					end_hit = (pm_q == 3'd2);
				end
				if (end_hit) begin
					stat_v = 1'b1;
					stat   = uud_pkg::ST_END;
					ph_n   = PH_DONE;
				end else if (pos_q == 7'd0) begin
					if (in_char < SPACE) begin
						stat_v = 1'b1;
						stat   = uud_pkg::ST_BADLINE;
						ph_n   = PH_DONE;
					end else begin
						cnt_n = sx;
						dec_n = 6'd0;
						pos_n = pos_q + 7'd1;
					end
				end else if (in_char == LF) begin
					emit    = (cnt_q != 6'd0) && (cnt_q <= MAX_CNT) && (dec_q == cnt_q);
					pos_n   = 7'd0;
					cnt_n   = 6'd0;
					carry_n = 6'd0;
					dec_n   = 6'd0;
					pm_n    = 3'd0;
				end else begin
					if (grp != 2'd0 && dec_q < cnt_q) begin
						unique case (grp)
							2'd1:    wr_data = {carry_q, sx[5:4]};
							2'd2:    wr_data = {carry_q[3:0], sx[5:2]};
							default: wr_data = {carry_q[1:0], sx};
						endcase
						// bytes past the largest count are never read back
						wr_en = (dec_q < MAX_CNT);
						dec_n = dec_q + 6'd1;
					end
					carry_n = sx;
					pos_n   = (pos_q != 7'd127) ? pos_q + 7'd1 : pos_q;
				end
			end
			default: begin
			end
		endcase
		if (in_fin) begin
			if (ph_n == PH_HDR) begin
				stat_v = 1'b1;
				stat   = (pm_n < 3'd6) ? uud_pkg::ST_BADHDR : uud_pkg::ST_NOEND;
			end else if (ph_n == PH_DATA) begin
				if (pos_n != 7'd0) begin
					emit     = (cnt_n != 6'd0) && (cnt_n <= MAX_CNT) && (dec_n == cnt_n);
					emit_cnt = cnt_n;
				end
				stat_v = 1'b1;
				stat   = uud_pkg::ST_NOEND;
			end
			ph_n    = PH_HDR;
			pos_n   = 7'd0;
			cnt_n   = 6'd0;
			carry_n = 6'd0;
			dec_n   = 6'd0;
			pm_n    = 3'd0;
		end
		wr_en = wr_en && accept;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR;
			pos_q   <= 7'd0;
			cnt_q   <= 6'd0;
			carry_q <= 6'd0;
			dec_q   <= 6'd0;
			pm_q    <= 3'd0;
			wbank_q <= 1'b0;
			busy_q  <= 2'b00;
		end else begin
			if (accept) begin
				phase_q <= ph_n;
				pos_q   <= pos_n;
				cnt_q   <= cnt_n;
				carry_q <= carry_n;
				dec_q   <= dec_n;
				pm_q    <= pm_n;
			end
			busy_q <= (busy_q & ~busy_clr) | busy_set;
			if (accept && emit) begin
				wbank_q <= !wbank_q;
			end
		end
	end

endmodule

`default_nettype wire

// File: sv/uud_back.sv
// back end: pops queued commands, reads line bytes from the store and
// drives the registered result channel; uses uud_pkg
`default_nettype none

module uud_back #(
	parameter int AW = 6
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire uud_pkg::cmd_t head,
	input  wire logic          q_empty,
	output logic               pop,
	output logic               rd_en,
	output logic               rd_bank,
	output logic [AW-1:0]      rd_idx,
	input  wire logic [7:0]    rd_data,
	output uud_pkg::rel_t      rel,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic [7:0]         out_byte,
	output logic [2:0]         out_stat,
	output logic               out_last
);

	typedef enum logic [1:0] {B_IDLE, B_BYTE, B_STAT} bstate_t;

	bstate_t       state_q;
	logic [AW-1:0] idx_q;
	logic          ofree;
	logic          last_byte;

	assign ofree     = !out_valid || out_ready;
	assign last_byte = (6'(idx_q) == head.count - 6'd1);
	assign rd_bank   = head.bank;

	always_comb begin
		rd_en     = 1'b0;
		rd_idx    = '0;
		pop       = 1'b0;
		rel.valid = 1'b0;
		rel.bank  = head.bank;
		unique case (state_q)
			B_IDLE: begin
				rd_en = !q_empty && head.has_line;
			end
			B_BYTE: begin
				if (ofree) begin
					if (last_byte) begin
						rel.valid = 1'b1;
						pop       = !head.has_stat;
					end else begin
						rd_en  = 1'b1;
						rd_idx = idx_q + AW'(1);
					end
				end
			end
			B_STAT: begin
				pop = ofree;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_IDLE;
			idx_q     <= '0;
			out_valid <= 1'b0;
			out_byte  <= 8'd0;
			out_stat  <= 3'd0;
			out_last  <= 1'b0;
		end else begin
			// output register loads a result whenever it is free and one is due
			if (ofree) begin
				out_valid <= (state_q == B_BYTE) || (state_q == B_STAT);
			end
			unique case (state_q)
				B_IDLE: begin
					idx_q <= '0;
					if (!q_empty) begin
						state_q <= head.has_line ? B_BYTE : B_STAT;
					end
				end
				B_BYTE: begin
					if (ofree) begin
						out_byte  <= rd_data;
						out_stat  <= uud_pkg::ST_DATA;
						out_last  <= last_byte && !head.has_stat;
						if (last_byte) begin
							state_q <= head.has_stat ? B_STAT : B_IDLE;
						end else begin
							idx_q <= idx_q + AW'(1);
						end
					end
				end
				B_STAT: begin
					if (ofree) begin
						out_byte  <= 8'd0;
						out_stat  <= head.stat;
						out_last  <= 1'b1;
						state_q   <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// File: sv/uudecode_line_stream_core.sv
// top level of the streaming uudecoder: front end, command queue, line store, back end
// depends on uud_pkg, uud_front, uud_cmdq, uud_lstore and uud_back
//
// The core takes uuencoded text one character per cycle on the slave stream
// and returns decoded bytes and status results on the master stream. The
// front end accepts a character in every cycle in which the command queue
// has room and the line bank it writes into is free; it decodes sextets into
// one of two line banks as they arrive. At a newline a complete line is handed
// to the back end as a single queued command, and the front end moves to the
// other bank, so decoding of the next line overlaps the draining of this one.
// Each command is taken up in the back end's idle state; for a line that
// state also issues the first store read, and while m_tready holds, one
// byte leaves per cycle. A character stalls only when both banks still hold
// lines not yet drained, or when two commands already wait in the queue. Status
// results (end found, bad header, bad line, missing end) follow any line bytes
// of the same character, and the last result of each character carries tlast.
`default_nettype none

module uudecode_line_stream_core #(
	parameter int MAX_LINE_BYTES = 63
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	// input text stream
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,   // [7:0] text_char
	input  wire logic       s_tlast,   // final_char: last character of the input
	// result stream
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata,   // [7:0] data_byte
	output logic [2:0]      m_tuser,   // [2:0] status
	output logic            m_tlast    // last_of_run
);

	// bank address width follows the largest byte count that can be emitted
	localparam int AW = $clog2(MAX_LINE_BYTES);

	// front to queue
	uud_pkg::cmd_t push_cmd;
	logic          cmd_push;
	logic          q_full;
	// queue to back
	uud_pkg::cmd_t head;
	logic          q_empty;
	logic          q_pop;
	// bank release from back to front
	uud_pkg::rel_t rel;
	// line store ports
	logic          wr_en;
	logic          wr_bank;
	logic [AW-1:0] wr_idx;
	logic [7:0]    wr_data;
	logic          rd_en;
	logic          rd_bank;
	logic [AW-1:0] rd_idx;
	logic [7:0]    rd_data;

	// header and line parsing, sextet decode
	uud_front #(
		.MAX_LINE_BYTES(MAX_LINE_BYTES),
		.AW            (AW)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.in_char (s_tdata),
		.in_fin  (s_tlast),
		.cmd_push(cmd_push),
		.cmd     (push_cmd),
		.q_full  (q_full),
		.rel     (rel),
		.wr_en   (wr_en),
		.wr_bank (wr_bank),
		.wr_idx  (wr_idx),
		.wr_data (wr_data)
	);

	// decouples character intake from result draining
	uud_cmdq u_cmdq (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (cmd_push),
		.push_cmd(push_cmd),
		.full    (q_full),
		.pop     (q_pop),
		.head    (head),
		.empty   (q_empty)
	);

	// ping-pong line banks
	uud_lstore #(
		.DEPTH(MAX_LINE_BYTES),
		.AW   (AW)
	) u_lstore (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_bank(wr_bank),
		.wr_idx (wr_idx),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_bank(rd_bank),
		.rd_idx (rd_idx),
		.rd_data(rd_data)
	);

	// result sequencing and output register
	uud_back #(
		.AW(AW)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.q_empty  (q_empty),
		.pop      (q_pop),
		.rd_en    (rd_en),
		.rd_bank  (rd_bank),
		.rd_idx   (rd_idx),
		.rd_data  (rd_data),
		.rel      (rel),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_byte (m_tdata),
		.out_stat (m_tuser),
		.out_last (m_tlast)
	);

endmodule

`default_nettype wire
